>>> sv/lmwq_pkg.sv
// lmwq_pkg: shared types and codes of the lock manager with wait queue
// no dependencies; imported by lmwq_out and lock_manager_with_wait_queue_top

package lmwq_pkg;

  // operation codes
  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  // wait modes
  localparam logic [1:0] MODE_NOW   = 2'd0;
  localparam logic [1:0] MODE_PROBE = 2'd1;
  localparam logic [1:0] MODE_WAIT  = 2'd2;
  localparam logic [1:0] MODE_TIMED = 2'd3;

  // response codes
  localparam logic [2:0] RSP_GRANTED  = 3'd0;
  localparam logic [2:0] RSP_LOCKED   = 3'd1;
  localparam logic [2:0] RSP_AGAIN    = 3'd2;
  localparam logic [2:0] RSP_TIMEDOUT = 3'd3;
  localparam logic [2:0] RSP_FULL     = 3'd4;

  // at most this many results per request
  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOCK_DEC,
    ST_REL_DEC,
    ST_GRANT_DEC,
    ST_TICK_DEC,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    SCAN_LOCK,
    SCAN_REL,
    SCAN_GRANT,
    SCAN_TICK
  } scan_e;

  // one slot of the client table memory
  typedef struct packed {
    logic [15:0] resource;
    logic [15:0] client;
    logic [1:0]  lock;
    logic [31:0] order;
    logic [31:0] deadline;
  } entry_t;

  // one response from the sequencer to the result stage
  typedef struct packed {
    logic        vld;
    logic [15:0] client;
    logic [15:0] res;
    logic [2:0]  code;
  } rsp_t;

endpackage

>>> sv/lock_manager_with_wait_queue_top.sv
// lock_manager_with_wait_queue_top: lock table sequencer over a slot memory
// depends on lmwq_pkg and lmwq_out
//
// Usage: drive a request with start_i while busy_o is low; it is taken at that edge.
// operation 0 locks, 1 releases, 2 advances the millisecond clock, 3 is ignored.
// The client table lives in a synchronous memory of CLIENTS slots; every decision
// comes from one pass over it, one slot read per cycle. A lock request needs one
// pass, plus one pass per waiter granted and one final pass when it queues; a
// release is alike; a tick needs one pass per expired waiter and one final pass,
// plus the granting passes. Results appear on result_valid_o for one cycle each,
// a pass or more apart; the final one of a request has last_o high and shows in
// the first cycle of busy_o low. The receiver cannot stall the results. Reset
// empties the table, clears the clock, the order counter and compat_matrix; no
// clearing pass is needed. compat_matrix sits at APB address 0; the user must
// see that it is written only while busy_o is low, as the block does not enforce it.

module lock_manager_with_wait_queue_top #(
  parameter int unsigned CLIENTS    = 16,
  parameter int unsigned LOCK_TYPES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] requester_id_i,
  input  logic [15:0] resource_id_i,
  input  logic [1:0]  lock_type_i,
  input  logic [1:0]  wait_mode_i,
  input  logic [15:0] timeout_ms_i,
  output logic        result_valid_o,
  output logic [15:0] client_id_o,
  output logic [15:0] target_resource_o,
  output logic [2:0]  response_code_o,
  output logic        last_o
);
  import lmwq_pkg::*;

  localparam int unsigned IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int unsigned CW = $clog2(CLIENTS + 1);

  // compatibility of a requested type with a held type
  function automatic logic compat_f(logic [1:0] r, logic [1:0] h, logic [15:0] m);
    int idx;
    idx = int'(r) * int'(LOCK_TYPES) + int'(h);
    if (int'(r) >= int'(LOCK_TYPES) || int'(h) >= int'(LOCK_TYPES) || idx >= 16) begin
      return 1'b0;
    end
    return m[idx[3:0]];
  endfunction

  // requested type fits every held type in the mask
  function automatic logic fits_f(logic [1:0] l, logic [3:0] mask, logic [15:0] m);
    logic ok;
    ok = 1'b1;
    for (int t = 0; t < 4; t++) begin
      if (mask[t] && !compat_f(l, 2'(t), m)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic before_f(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  // configuration register
  logic [15:0] cm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      cm_q <= pwdata[15:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, cm_q};

  // control and request registers
  state_e        state_q, state_d;
  scan_e         kind_q, kind_d;
  logic          in_tick_q, in_tick_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   client_q, client_d;
  logic [15:0]   cur_res_q, cur_res_d;
  logic [1:0]    lock_q, lock_d;
  logic [1:0]    mode_q, mode_d;
  logic [15:0]   tmo_q, tmo_d;
  logic [31:0]   now_q, now_d;
  logic [31:0]   order_q, order_d;

  // slot flags
  logic [CLIENTS-1:0] valid_q, valid_d;
  logic [CLIENTS-1:0] active_q, active_d;
  logic [CLIENTS-1:0] hasdl_q, hasdl_d;

  // pass accumulators
  logic          pair_hit_q, pair_hit_d;
  logic [IW-1:0] pair_idx_q, pair_idx_d;
  logic          conf_q, conf_d;
  logic [3:0]    mask_q, mask_d;
  logic          free_hit_q, free_hit_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic          head_hit_q, head_hit_d;
  logic [IW-1:0] head_idx_q, head_idx_d;
  logic [31:0]   head_order_q, head_order_d;
  logic [15:0]   head_client_q, head_client_d;
  logic [1:0]    head_lock_q, head_lock_d;
  logic          pick_hit_q, pick_hit_d;
  logic [IW-1:0] pick_idx_q, pick_idx_d;
  logic [31:0]   pick_age_q, pick_age_d;
  logic [31:0]   pick_order_q, pick_order_d;
  logic [15:0]   pick_client_q, pick_client_d;
  logic [15:0]   pick_res_q, pick_res_d;

  // slot memory
  entry_t        mem [CLIENTS];
  entry_t        rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] raddr;

  rsp_t rsp;
  logic flush;

  assign raddr = cnt_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[raddr];
  end

  // sequencer
  always_comb begin
    logic          go_scan;
    scan_e         go_kind;
    logic [IW-1:0] sidx;
    logic          v, a, h, rm;
    logic [31:0]   age;

    state_d = state_q;  kind_d = kind_q;  in_tick_d = in_tick_q;  cnt_d = cnt_q;
    client_d = client_q;  cur_res_d = cur_res_q;  lock_d = lock_q;
    mode_d = mode_q;  tmo_d = tmo_q;  now_d = now_q;  order_d = order_q;
    valid_d = valid_q;  active_d = active_q;  hasdl_d = hasdl_q;
    pair_hit_d = pair_hit_q;  pair_idx_d = pair_idx_q;  conf_d = conf_q;
    mask_d = mask_q;  free_hit_d = free_hit_q;  free_idx_d = free_idx_q;
    head_hit_d = head_hit_q;  head_idx_d = head_idx_q;  head_order_d = head_order_q;
    head_client_d = head_client_q;  head_lock_d = head_lock_q;
    pick_hit_d = pick_hit_q;  pick_idx_d = pick_idx_q;  pick_age_d = pick_age_q;
    pick_order_d = pick_order_q;  pick_client_d = pick_client_q;  pick_res_d = pick_res_q;
    mem_we = 1'b0;  mem_waddr = free_idx_q;
    mem_wdata = '{resource: cur_res_q, client: client_q, lock: lock_q,
                  order: order_q, deadline: now_q + 32'(tmo_q)};
    rsp = '{vld: 1'b0, client: client_q, res: cur_res_q, code: RSP_GRANTED};
    flush = 1'b0;
    go_scan = 1'b0;  go_kind = SCAN_LOCK;
    sidx = IW'(cnt_q - CW'(1));
    v = valid_q[sidx];  a = active_q[sidx];  h = hasdl_q[sidx];
    rm = (rd_q.resource == cur_res_q);
    age = now_q - rd_q.deadline;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          client_d = requester_id_i;  cur_res_d = resource_id_i;
          lock_d = lock_type_i;  mode_d = wait_mode_i;  tmo_d = timeout_ms_i;
          in_tick_d = 1'b0;
          unique case (operation_i)
            OP_LOCK:    begin go_scan = 1'b1; go_kind = SCAN_LOCK; end
            OP_RELEASE: begin go_scan = 1'b1; go_kind = SCAN_REL; end
            OP_TICK: begin
              now_d = now_q + 32'd1;  in_tick_d = 1'b1;
              go_scan = 1'b1;  go_kind = SCAN_TICK;
            end
            default: state_d = ST_FLUSH;
          endcase
        end
      end

      // one slot per cycle, data of slot cnt-1 arrives now
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          if (v && rd_q.client == client_q && rm && !pair_hit_q) begin
            pair_hit_d = 1'b1;  pair_idx_d = sidx;
          end
          if (!v && !free_hit_q) begin
            free_hit_d = 1'b1;  free_idx_d = sidx;
          end
          if (v && a && rm) begin
            mask_d[rd_q.lock] = 1'b1;
            if (!compat_f(lock_q, rd_q.lock, cm_q)) conf_d = 1'b1;
          end
          if (v && !a && rm && (!head_hit_q || before_f(rd_q.order, head_order_q))) begin
            head_hit_d = 1'b1;  head_idx_d = sidx;  head_order_d = rd_q.order;
            head_client_d = rd_q.client;  head_lock_d = rd_q.lock;
          end
          if (v && !a && h && !age[31] &&
              (!pick_hit_q || age > pick_age_q ||
               (age == pick_age_q && before_f(rd_q.order, pick_order_q)))) begin
            pick_hit_d = 1'b1;  pick_idx_d = sidx;  pick_age_d = age;
            pick_order_d = rd_q.order;  pick_client_d = rd_q.client;
            pick_res_d = rd_q.resource;
          end
        end
        if (cnt_q == CW'(CLIENTS)) begin
          unique case (kind_q)
            SCAN_LOCK:  state_d = ST_LOCK_DEC;
            SCAN_REL:   state_d = ST_REL_DEC;
            SCAN_GRANT: state_d = ST_GRANT_DEC;
            SCAN_TICK:  state_d = ST_TICK_DEC;
          endcase
        end
      end

      // lock request decision
      ST_LOCK_DEC: begin
        rsp.vld = 1'b1;
        state_d = ST_FLUSH;
        if (pair_hit_q) begin
          rsp.code = RSP_AGAIN;
        end else if (mode_q == MODE_PROBE) begin
          rsp.code = conf_q ? RSP_LOCKED : RSP_GRANTED;
        end else if (mode_q == MODE_NOW) begin
          if (conf_q) begin
            rsp.code = RSP_LOCKED;
          end else if (!free_hit_q) begin
            rsp.code = RSP_FULL;
          end else begin
            mem_we = 1'b1;  order_d = order_q + 32'd1;
            valid_d[free_idx_q] = 1'b1;  active_d[free_idx_q] = 1'b1;
            hasdl_d[free_idx_q] = 1'b0;
            rsp.code = RSP_GRANTED;
          end
        end else if (!free_hit_q) begin
          rsp.code = RSP_FULL;
        end else begin
          rsp.vld = 1'b0;
          mem_we = 1'b1;  order_d = order_q + 32'd1;
          valid_d[free_idx_q] = 1'b1;  active_d[free_idx_q] = 1'b0;
          hasdl_d[free_idx_q] = (mode_q == MODE_TIMED) && (tmo_q != 16'd0);
          go_scan = 1'b1;  go_kind = SCAN_GRANT;
        end
      end

      // release decision
      ST_REL_DEC: begin
        state_d = ST_FLUSH;
        if (pair_hit_q) begin
          valid_d[pair_idx_q] = 1'b0;  active_d[pair_idx_q] = 1'b0;
          hasdl_d[pair_idx_q] = 1'b0;
          if (active_q[pair_idx_q]) begin
            go_scan = 1'b1;  go_kind = SCAN_GRANT;
          end
        end
      end

      // grant the queue head if it fits every holder, else resume the tick or finish
      ST_GRANT_DEC: begin
        if (head_hit_q && fits_f(head_lock_q, mask_q, cm_q)) begin
          active_d[head_idx_q] = 1'b1;  hasdl_d[head_idx_q] = 1'b0;
          rsp.vld = 1'b1;  rsp.client = head_client_q;  rsp.code = RSP_GRANTED;
          go_scan = 1'b1;  go_kind = SCAN_GRANT;
        end else if (in_tick_q) begin
          go_scan = 1'b1;  go_kind = SCAN_TICK;
        end else begin
          state_d = ST_FLUSH;
        end
      end

      // drop the most overdue waiter, then grant on its resource
      ST_TICK_DEC: begin
        if (pick_hit_q) begin
          rsp.vld = 1'b1;  rsp.client = pick_client_q;  rsp.res = pick_res_q;
          rsp.code = RSP_TIMEDOUT;
          valid_d[pick_idx_q] = 1'b0;  hasdl_d[pick_idx_q] = 1'b0;
          cur_res_d = pick_res_q;
          go_scan = 1'b1;  go_kind = SCAN_GRANT;
        end else begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        flush = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    // start a new pass over the table
    if (go_scan) begin
      state_d = ST_SCAN;  kind_d = go_kind;  cnt_d = '0;
      pair_hit_d = 1'b0;  conf_d = 1'b0;  mask_d = '0;  free_hit_d = 1'b0;
      head_hit_d = 1'b0;  pick_hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  kind_q <= SCAN_LOCK;  in_tick_q <= 1'b0;  cnt_q <= '0;
      now_q <= '0;  order_q <= '0;
      valid_q <= '0;  active_q <= '0;  hasdl_q <= '0;
      pair_hit_q <= 1'b0;  conf_q <= 1'b0;  mask_q <= '0;  free_hit_q <= 1'b0;
      head_hit_q <= 1'b0;  pick_hit_q <= 1'b0;
    end else begin
      state_q <= state_d;  kind_q <= kind_d;  in_tick_q <= in_tick_d;  cnt_q <= cnt_d;
      now_q <= now_d;  order_q <= order_d;
      valid_q <= valid_d;  active_q <= active_d;  hasdl_q <= hasdl_d;
      pair_hit_q <= pair_hit_d;  conf_q <= conf_d;  mask_q <= mask_d;
      free_hit_q <= free_hit_d;  head_hit_q <= head_hit_d;  pick_hit_q <= pick_hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    client_q <= client_d;  cur_res_q <= cur_res_d;  lock_q <= lock_d;
    mode_q <= mode_d;  tmo_q <= tmo_d;
    pair_idx_q <= pair_idx_d;  free_idx_q <= free_idx_d;
    head_idx_q <= head_idx_d;  head_order_q <= head_order_d;
    head_client_q <= head_client_d;  head_lock_q <= head_lock_d;
    pick_idx_q <= pick_idx_d;  pick_age_q <= pick_age_d;  pick_order_q <= pick_order_d;
    pick_client_q <= pick_client_d;  pick_res_q <= pick_res_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  // result stage
  lmwq_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rsp_i             (rsp),
    .flush_i           (flush),
    .result_valid_o    (result_valid_o),
    .client_id_o       (client_id_o),
    .target_resource_o (target_resource_o),
    .response_code_o   (response_code_o),
    .last_o            (last_o)
  );

  // checks
  a_active_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~valid_q) == '0)
    else $error("active slot without valid");

  a_request_makes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result after final response");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("final response while still busy");

endmodule

>>> sv/lmwq_out.sv
// lmwq_out: result stage; holds one response back so the final one carries last
// depends on lmwq_pkg

module lmwq_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lmwq_pkg::rsp_t  rsp_i,
  input  logic            flush_i,
  output logic            result_valid_o,
  output logic [15:0]     client_id_o,
  output logic [15:0]     target_resource_o,
  output logic [2:0]      response_code_o,
  output logic            last_o
);
  import lmwq_pkg::*;

  logic             pend_vld_q, pend_vld_d;
  rsp_t             pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic             out_last_q, out_last_d;
  rsp_t             out_q, out_d;

  // pending slot, drop beyond the per-request limit
  always_comb begin
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    out_vld_d  = 1'b0;
    out_last_d = 1'b0;
    out_d      = pend_q;
    if (rsp_i.vld && (cnt_q < CNT_W'(MAX_OUT))) begin
      out_vld_d  = pend_vld_q;
      pend_d     = rsp_i;
      pend_vld_d = 1'b1;
      cnt_d      = cnt_q + CNT_W'(1);
    end
    if (flush_i) begin
      out_vld_d  = pend_vld_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
      cnt_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign result_valid_o    = out_vld_q;
  assign client_id_o       = out_q.client;
  assign target_resource_o = out_q.res;
  assign response_code_o   = out_q.code;
  assign last_o            = out_last_q;

endmodule
